// File: sv/bsp_pkg.sv
// Package with the shared types and constants of the bit and byte stream packer.
package bsp_pkg;

  localparam int unsigned MAX_RES = 5;
  localparam logic [5:0] MAX_BITS = 6'd32;

  typedef enum logic [2:0] {
    OP_BITS  = 3'd0,
    OP_BYTE  = 3'd1,
    OP_SHORT = 3'd2,
    OP_INT   = 3'd3,
    OP_ALIGN = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] value;
    logic [5:0]  bit_count;
  } item_t;

  // Outcome of one request: the bytes to send in stream order and the new state.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [2:0]              count;
    logic [7:0]              partial;
    logic [2:0]              offset;
  } pack_res_t;

endpackage

// File: sv/bsp_if.sv
// Valid/ready channel interfaces for the request and result streams.
interface bsp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] value;
  logic [5:0]  bit_count;

  modport source (output valid, output op, output value, output bit_count, input ready);
  modport sink (input valid, input op, input value, input bit_count, output ready);
endinterface

interface bsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

// File: sv/bsp_pack.sv
// Combinational packer: turns one request and the current partial byte into output bytes.
module bsp_pack
  import bsp_pkg::*;
(
  input  item_t     item,
  input  logic [7:0] partial,
  input  logic [2:0] offset,
  output pack_res_t res
);

  logic [5:0]  nsat;
  logic [31:0] v_al;
  logic [39:0] w;
  logic [6:0]  total;
  logic [2:0]  nbytes;
  logic [4:0][7:0] wb;
  logic [4:0][7:0] lb;
  logic        pre;
  logic [2:0]  pre_cnt;

  always_comb begin
    nsat  = (item.bit_count > MAX_BITS) ? MAX_BITS : item.bit_count;
    v_al  = item.value << (MAX_BITS - nsat);
    // Stream window: the held bits first, then the new bits right behind them.
    w     = ({v_al, 8'h00} >> offset) | {partial, 32'h0};
    total = {4'b0, offset} + {1'b0, nsat};
    nbytes = total[5:3];
    for (int i = 0; i < 5; i++) begin
      wb[i] = w[39 - 8*i -: 8];
    end

    // Byte-oriented writes: the padded partial byte goes out ahead of the value.
    pre     = (offset != 3'd0);
    pre_cnt = {2'b0, pre};
    lb[0] = pre ? partial : item.value[7:0];
    for (int i = 1; i < 4; i++) begin
      lb[i] = pre ? item.value[8*(i-1) +: 8] : item.value[8*i +: 8];
    end
    lb[4] = pre ? item.value[31:24] : 8'h00;

    res.bytes   = lb;
    res.count   = 3'd0;
    res.partial = partial;
    res.offset  = offset;
    case (op_t'(item.op))
      OP_BITS: begin
        res.bytes   = wb;
        res.count   = nbytes;
        res.partial = wb[nbytes];
        res.offset  = total[2:0];
      end
      OP_BYTE: begin
        res.count   = pre_cnt + 3'd1;
        res.partial = 8'h00;
        res.offset  = 3'd0;
      end
      OP_SHORT: begin
        res.count   = pre_cnt + 3'd2;
        res.partial = 8'h00;
        res.offset  = 3'd0;
      end
      OP_INT: begin
        res.count   = pre_cnt + 3'd4;
        res.partial = 8'h00;
        res.offset  = 3'd0;
      end
      OP_ALIGN: begin
        res.count   = pre_cnt;
        res.partial = 8'h00;
        res.offset  = 3'd0;
      end
      default: begin
        res.count = 3'd0;
      end
    endcase
  end

endmodule

// File: sv/bsp_obuf.sv
// Output buffer that holds the bytes of one request and sends them one per cycle while out_if.ready is high.
module bsp_obuf
  import bsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  pack_res_t res,
  output logic      can_load,
  bsp_out_if.source out_if
);

  logic [MAX_RES-1:0][7:0] bytes_r, bytes_nxt;
  logic [2:0]              cnt_r, cnt_nxt;
  logic                    pop;

  assign pop             = (cnt_r != 3'd0) && out_if.ready;
  assign can_load        = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_if.ready);
  assign out_if.valid    = (cnt_r != 3'd0);
  assign out_if.out_byte = bytes_r[0];
  assign out_if.last     = (cnt_r == 3'd1);

  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      bytes_nxt = res.bytes;
      cnt_nxt   = res.count;
    end else if (pop) begin
      bytes_nxt = {8'h00, bytes_r[MAX_RES-1:1]};
      cnt_nxt   = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(MAX_RES)) else $error("byte count beyond buffer depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == 3'd0 || (cnt_r == 3'd1 && pop)))
    else $error("buffer reloaded with bytes still pending");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !load) |=> (cnt_r == $past(cnt_r) - 3'd1))
    else $error("byte count did not step down on a send");

endmodule

// File: sv/bit_and_byte_stream_packer.sv
// Top level of the MSB-first bit and byte stream packer.
//
// Requests arrive on in_if (op, value, bit_count) under a valid/ready handshake
// and the packed byte stream leaves on out_if, one byte per transfer, with last
// set on the final byte that a request produces. A request is taken into an
// input register; from there the packer works out all of its bytes and the
// new partial byte at once, and they are loaded into the output buffer once it
// can take them, so the first byte of a request is offered from the output
// buffer register, behind the input register.
// The output buffer sends one byte per cycle while out_if.ready is high. A
// request makes up to 4 bytes for a 32-bit write and 5 for an int write
// behind a partial byte; one that makes no bytes leaves the input register
// without loading the buffer. The next request's bytes are loaded in the same
// cycle that the last byte of the previous one is taken, so there are no gaps.
// Reset (rst_n low at a clock edge) empties both registers and clears the
// partial byte and bit offset. When the receiver holds out_if.ready low, the
// buffer holds its byte; the input register still takes one more request and
// then in_if.ready drops until the buffer can take that request's bytes.
// Requests that make no bytes update the partial byte even during a stall.
module bit_and_byte_stream_packer
  import bsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  bsp_in_if.sink    in_if,
  bsp_out_if.source out_if
);

  item_t      item_r;
  logic       in_vld_r;
  logic [7:0] partial_r;
  logic [2:0] offset_r;
  pack_res_t  res;
  logic       can_load;
  logic       adv;
  logic       load;

  // The packer sees the registered request and the stored partial byte.
  bsp_pack u_pack (
    .item    (item_r),
    .partial (partial_r),
    .offset  (offset_r),
    .res     (res)
  );

  // A request leaves the input register when its bytes fit into the buffer,
  // or at once when it makes no bytes at all.
  assign adv         = in_vld_r && ((res.count == 3'd0) || can_load);
  assign load        = adv && (res.count != 3'd0);
  assign in_if.ready = !in_vld_r || adv;

  bsp_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .res      (res),
    .can_load (can_load),
    .out_if   (out_if)
  );

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_r.op        <= in_if.op;
      item_r.value     <= in_if.value;
      item_r.bit_count <= in_if.bit_count;
    end
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      partial_r <= 8'h00;
      offset_r  <= 3'd0;
    end else begin
      if (in_if.ready) begin
        in_vld_r <= in_if.valid;
      end
      if (adv) begin
        partial_r <= res.partial;
        offset_r  <= res.offset;
      end
    end
  end

endmodule
